[sv/frbd_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and sequencer codes for the frame rate burst decimator
package frbd_pkg;

    localparam int TIME_W             = 48;
    localparam int PERIOD_W           = 32;
    localparam int INDEX_W            = 32;
    localparam int RATE_W             = 32;
    localparam int BURST_W            = 16;
    localparam int POS_W              = BURST_W + 1;
    localparam int PROD_W             = TIME_W + RATE_W;
    localparam int MUL_STEPS          = RATE_W;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 32;
    localparam int DEF_TIME_FRAC_BITS = 24;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(32'h0001_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RATE = 2'd0,
        CFG_BURST_PASS  = 2'd1,
        CFG_BURST_SKIP  = 2'd2,
        CFG_RENUMBER    = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIME,
        ST_MUL,
        ST_CMP,
        ST_MOD,
        ST_ADDP,
        ST_GATE,
        ST_RESULT
    } state_t;

    // sequencer to datapath
    typedef struct packed {
        logic in_ready;
        logic do_capture;
        logic do_time;
        logic do_mul;
        logic do_cmp;
        logic do_mod;
        logic do_addp;
        logic do_gate;
        logic out_load;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic timed;
        logic first;
        logic cmp_drop;
        logic burst_en;
        logic out_free;
    } stat_t;

endpackage

[sv/frbd_in_if.sv]
`timescale 1ns / 1ps
// input channel: one frame timestamp word per handshake
interface frbd_in_if
    import frbd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                time_present;
    logic                frame_present;
    logic [TIME_W-1:0]   frame_time;
    logic [PERIOD_W-1:0] source_period;
    logic [INDEX_W-1:0]  frame_index;

    modport source (
        output valid, time_present, frame_present, frame_time, source_period, frame_index,
        input  ready
    );
    modport sink (
        input  valid, time_present, frame_present, frame_time, source_period, frame_index,
        output ready
    );
endinterface

[sv/frbd_out_if.sv]
`timescale 1ns / 1ps
// output channel: one pass or drop decision word per handshake
interface frbd_out_if
    import frbd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               pass_frame;
    logic [INDEX_W-1:0] frame_index_out;
    logic               frame_present_out;

    modport source (
        output valid, pass_frame, frame_index_out, frame_present_out,
        input  ready
    );
    modport sink (
        input  valid, pass_frame, frame_index_out, frame_present_out,
        output ready
    );
endinterface

[sv/frame_rate_burst_decimator.sv]
`timescale 1ns / 1ps
// an untimed word goes from acceptance straight to the result; a timed word takes the time update,
// the multiply and the rate test, and the burst modulo and gate unless the rate test drops it or
// the burst gate is off; the multiply takes 32 steps and the modulo one step per bin bit plus one
// on one adder; the block takes no new word until the current one is done
// a finished result waits in the output register; a full one holds the sequencer until taken
// reset (rst_n, asynchronous, active low) restores the register defaults and clears all state
module frame_rate_burst_decimator
    import frbd_pkg::*;
#(
    parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    frbd_in_if.sink               in_ch,
    frbd_out_if.source            out_ch
);
    // bin = product >> (frac + 16), so the bin keeps the upper 64 - frac bits of the product
    localparam int BIN_LSB = TIME_FRAC_BITS + 16;
    localparam int BIN_W   = PROD_W - BIN_LSB;
    // elapsed bins plus burst position need one bit more than a bin
    localparam int ELAP_W  = BIN_W + 1;
    localparam int ALU_W   = (ELAP_W > TIME_W + 1) ? ELAP_W : TIME_W + 1;

    ctrl_t ctrl;
    stat_t stat;

    // configuration registers
    logic [RATE_W-1:0]  rate_reg;
    logic [BURST_W-1:0] pass_cnt_reg;
    logic [BURST_W-1:0] skip_cnt_reg;
    logic               renum_reg;

    // captured input word
    logic                tp_reg;
    logic                fp_reg;
    logic [TIME_W-1:0]   ftime_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [INDEX_W-1:0]  findex_reg;

    // timing and burst state
    logic [TIME_W-1:0]  cur_time_reg;
    logic [BIN_W-1:0]   last_bin_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [INDEX_W-1:0] out_count_reg;
    logic               first_reg;

    // working registers
    logic [PROD_W-1:0] prod_reg;
    logic [ELAP_W-1:0] elapsed_reg;
    logic [POS_W:0]    rem_reg;
    logic [POS_W-1:0]  mod_reg;
    logic              drop_reg;

    // output register
    logic               ov_reg;
    logic               opass_reg;
    logic [INDEX_W-1:0] oidx_reg;
    logic               opres_reg;

    // shared adder
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub, alu_carry;

    logic [BIN_W-1:0] bin;
    logic [POS_W:0]   mod_trial;
    logic [POS_W-1:0] pos_next;
    logic             burst_en;
    logic             cmp_drop;

    assign bin       = prod_reg[PROD_W-1:BIN_LSB];
    assign burst_en  = (pass_cnt_reg != '0) && (skip_cnt_reg != '0);
    // long division of position plus elapsed bins by the burst cycle length,
    // one bit shifted in per step
    assign mod_trial = {rem_reg[POS_W-1:0], elapsed_reg[ELAP_W-1]};
    // frame is late enough only when its bin is strictly above the last passed bin
    assign cmp_drop  = !alu_carry || (alu_res[BIN_W-1:0] == '0);
    // remainder left by the division is the new burst position
    assign pos_next  = rem_reg[POS_W-1:0];

    assign stat.in_valid = in_ch.valid;
    assign stat.timed    = in_ch.time_present || in_ch.frame_present;
    assign stat.first    = first_reg;
    assign stat.cmp_drop = cmp_drop;
    assign stat.burst_en = burst_en;
    assign stat.out_free = !ov_reg || out_ch.ready;

    frbd_seq #(
        .MOD_STEPS (ELAP_W)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // operand selection for the shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        if (ctrl.do_time)
        begin
            alu_a = ALU_W'(cur_time_reg);
            alu_b = ALU_W'(period_reg);
        end
        else if (ctrl.do_mul)
        begin
            alu_a = ALU_W'(prod_reg[PROD_W-1:RATE_W]);
            alu_b = prod_reg[0] ? ALU_W'(cur_time_reg) : '0;
        end
        else if (ctrl.do_cmp)
        begin
            alu_a   = ALU_W'(bin);
            alu_b   = ALU_W'(last_bin_reg);
            alu_sub = 1'b1;
        end
        else if (ctrl.do_addp)
        begin
            alu_a = ALU_W'(elapsed_reg);
            alu_b = ALU_W'(pos_reg);
        end
        else if (ctrl.do_mod)
        begin
            alu_a   = ALU_W'(mod_trial);
            alu_b   = ALU_W'(mod_reg);
            alu_sub = 1'b1;
        end
    end

    frbd_alu #(
        .W (ALU_W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .carry (alu_carry)
    );

    // configuration port; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= RATE_RESET;
            pass_cnt_reg <= '0;
            skip_cnt_reg <= '0;
            renum_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_TARGET_RATE: rate_reg     <= cfg_data[RATE_W-1:0];
                CFG_BURST_PASS:  pass_cnt_reg <= cfg_data[BURST_W-1:0];
                CFG_BURST_SKIP:  skip_cnt_reg <= cfg_data[BURST_W-1:0];
                CFG_RENUMBER:    renum_reg    <= cfg_data[0];
                default:         renum_reg    <= renum_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_time_reg  <= '0;
            last_bin_reg  <= '0;
            pos_reg       <= '0;
            out_count_reg <= '0;
            first_reg     <= 1'b1;
            drop_reg      <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (ctrl.do_capture)
                drop_reg <= 1'b0;

            // frame time: given, or previous plus period saturating at full scale
            if (ctrl.do_time)
            begin
                if (tp_reg)
                    cur_time_reg <= ftime_reg;
                else if (alu_res[TIME_W])
                    cur_time_reg <= '1;
                else
                    cur_time_reg <= alu_res[TIME_W-1:0];
            end

            if (ctrl.do_cmp)
            begin
                if (first_reg)
                begin
                    first_reg    <= 1'b0;
                    last_bin_reg <= bin;
                end
                else if (cmp_drop)
                    drop_reg <= 1'b1;
                else
                    last_bin_reg <= bin;
            end

            // burst gate passes only while the position is in 1..pass count
            if (ctrl.do_gate)
            begin
                pos_reg  <= pos_next;
                drop_reg <= (pos_next == '0) || (pos_next > POS_W'(pass_cnt_reg));
            end

            if (ctrl.out_load)
            begin
                ov_reg <= 1'b1;
                if (!drop_reg && renum_reg)
                    out_count_reg <= out_count_reg + 1'b1;
            end
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.do_capture)
        begin
            tp_reg     <= in_ch.time_present;
            fp_reg     <= in_ch.frame_present;
            ftime_reg  <= in_ch.frame_time;
            period_reg <= in_ch.source_period;
            findex_reg <= in_ch.frame_index;
        end

        if (ctrl.do_time)
        begin
            prod_reg <= {{TIME_W{1'b0}}, rate_reg};
            mod_reg  <= {1'b0, pass_cnt_reg} + {1'b0, skip_cnt_reg};
        end

        // shift-add multiply, low bits of the rate retire as the product moves in
        if (ctrl.do_mul)
            prod_reg <= {alu_res[TIME_W:0], prod_reg[RATE_W-1:1]};

        if (ctrl.do_cmp)
        begin
            rem_reg     <= '0;
            elapsed_reg <= first_reg ? ELAP_W'(1) : ELAP_W'(alu_res[BIN_W-1:0]);
        end

        // old position joins the dividend, so any stale position is reduced too
        if (ctrl.do_addp)
            elapsed_reg <= alu_res[ELAP_W-1:0];

        if (ctrl.do_mod)
        begin
            rem_reg     <= alu_carry ? alu_res[POS_W:0] : mod_trial;
            elapsed_reg <= {elapsed_reg[ELAP_W-2:0], 1'b0};
        end

        if (ctrl.out_load)
        begin
            if (drop_reg)
            begin
                opass_reg <= 1'b0;
                oidx_reg  <= '0;
                opres_reg <= 1'b0;
            end
            else if (renum_reg)
            begin
                opass_reg <= 1'b1;
                oidx_reg  <= out_count_reg;
                opres_reg <= 1'b1;
            end
            else
            begin
                opass_reg <= 1'b1;
                oidx_reg  <= fp_reg ? findex_reg : '0;
                opres_reg <= fp_reg;
            end
        end
    end

    assign in_ch.ready              = ctrl.in_ready;
    assign out_ch.valid             = ov_reg;
    assign out_ch.pass_frame        = opass_reg;
    assign out_ch.frame_index_out   = oidx_reg;
    assign out_ch.frame_present_out = opres_reg;

endmodule

[sv/frbd_alu.sv]
`timescale 1ns / 1ps
// shared add / subtract unit with carry out
module frbd_alu
    import frbd_pkg::*;
#(
    parameter int W = 49
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] res,
    output logic         carry
);
    logic [W:0] sum;

    // on subtract, carry set means no borrow (a >= b)
    assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    assign res   = sum[W-1:0];
    assign carry = sum[W];
endmodule

[sv/frbd_seq.sv]
`timescale 1ns / 1ps
// sequencer: steps one word through time update, multiply, compare, modulo and burst gate to the result
module frbd_seq
    import frbd_pkg::*;
#(
    parameter int MOD_STEPS = 41
) (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);
    localparam int STEPS_MAX = (MOD_STEPS > MUL_STEPS) ? MOD_STEPS : MUL_STEPS;
    localparam int CNT_W     = $clog2(STEPS_MAX);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mul_last, mod_last;

    assign mul_last = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign mod_last = (cnt_reg == CNT_W'(MOD_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_valid)
                    state_next = stat.timed ? ST_TIME : ST_RESULT;
            end
            ST_TIME:
                state_next = ST_MUL;
            ST_MUL:
            begin
                if (mul_last)
                    state_next = ST_CMP;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_CMP:
            begin
                if (!stat.first && stat.cmp_drop)
                    state_next = ST_RESULT;
                else
                    state_next = stat.burst_en ? ST_ADDP : ST_RESULT;
            end
            ST_ADDP:
                state_next = ST_MOD;
            ST_MOD:
            begin
                if (mod_last)
                    state_next = ST_GATE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_GATE:
                state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready   = 1'b1;
                ctrl.do_capture = stat.in_valid;
            end
            ST_TIME:   ctrl.do_time  = 1'b1;
            ST_MUL:    ctrl.do_mul   = 1'b1;
            ST_CMP:    ctrl.do_cmp   = 1'b1;
            ST_MOD:    ctrl.do_mod   = 1'b1;
            ST_ADDP:   ctrl.do_addp  = 1'b1;
            ST_GATE:   ctrl.do_gate  = 1'b1;
            ST_RESULT: ctrl.out_load = stat.out_free;
            default:   ctrl = '0;
        endcase
    end
endmodule

[sv/frbd_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the frame rate burst decimator, bound to the top level
module frbd_checker
    import frbd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               out_pass,
    input logic [INDEX_W-1:0] out_index,
    input logic               out_present
);
    // one word at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in progress");

    // no result can appear in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // dropped frames carry no frame number
    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_pass |-> (out_index == '0) && !out_present)
        else $error("dropped word carries a frame number");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pass) && $stable(out_index)
            && $stable(out_present))
        else $error("stalled result changed");
endmodule

bind frame_rate_burst_decimator frbd_checker u_frbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_pass    (out_ch.pass_frame),
    .out_index   (out_ch.frame_index_out),
    .out_present (out_ch.frame_present_out)
);

[bench/frame_rate_burst_decimator_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the frame rate burst decimator
module frame_rate_burst_decimator_test;
    import frbd_pkg::*;

    // frame time arithmetic follows the block's default fixed-point format
    localparam int FRAC_BITS = DEF_TIME_FRAC_BITS;
    localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 64'd1;
    localparam longint unsigned PERIOD_MAX = (64'd1 << PERIOD_W) - 64'd1;
    // settling time, comfortably covering the slowest timed word in flight
    localparam int SETTLE_CYCLES = 100;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one input word and one decision word, as seen on the channels
    typedef struct packed {
        logic                time_present;
        logic                frame_present;
        logic [TIME_W-1:0]   frame_time;
        logic [PERIOD_W-1:0] source_period;
        logic [INDEX_W-1:0]  frame_index;
    } frame_word_t;

    typedef struct packed {
        logic               pass_frame;
        logic [INDEX_W-1:0] frame_index_out;
        logic               frame_present_out;
    } decision_t;

    // shadow of the decimator: register copies, timing state and the queue of
    // decisions still owed by the block
    class decision_scoreboard;
        logic [RATE_W-1:0]  rate;
        logic [BURST_W-1:0] pass_count;
        logic [BURST_W-1:0] skip_count;
        logic               renumber;
        logic [TIME_W-1:0]  cur_time;
        logic [41:0]        last_bin;
        logic [POS_W-1:0]   burst_pos;
        logic [INDEX_W-1:0] out_count;
        logic               first_pending;
        decision_t          pending_decisions[$];
        int unsigned        faults;

        function new();
            rate          = RATE_RESET;
            pass_count    = '0;
            skip_count    = '0;
            renumber      = 1'b0;
            cur_time      = '0;
            last_bin      = '0;
            burst_pos     = '0;
            out_count     = '0;
            first_pending = 1'b1;
            faults        = 0;
        endfunction

        function void note_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TARGET_RATE: rate       = data[RATE_W-1:0];
                CFG_BURST_PASS:  pass_count = data[BURST_W-1:0];
                CFG_BURST_SKIP:  skip_count = data[BURST_W-1:0];
                CFG_RENUMBER:    renumber   = data[0];
                default: ;
            endcase
        endfunction

        // advances the frame clock and the rate and burst gates, 1 means drop
        function bit timing_drop(frame_word_t w);
            logic [PROD_W-1:0] prod;
            logic [TIME_W:0]   sum;
            logic [41:0]       bin;
            logic [41:0]       elapsed;
            logic [POS_W-1:0]  modulus;
            if (w.time_present)
                cur_time = w.frame_time;
            else
            begin
                sum = {1'b0, cur_time} + (TIME_W+1)'(w.source_period);
                cur_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end
            prod = PROD_W'(cur_time) * PROD_W'(rate);
            bin = 42'(prod >> (FRAC_BITS + 16));
            if (first_pending)
            begin
                first_pending = 1'b0;
                elapsed = 42'd1;
            end
            else
            begin
                if (bin <= last_bin)
                    return 1'b1;
                elapsed = bin - last_bin;
            end
            last_bin = bin;
            if (pass_count != 0 && skip_count != 0)
            begin
                modulus = POS_W'(pass_count) + POS_W'(skip_count);
                burst_pos = POS_W'((64'(burst_pos) + 64'(elapsed) % 64'(modulus))
                                   % 64'(modulus));
                if (burst_pos == 0 || burst_pos > POS_W'(pass_count))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_frame(frame_word_t w);
            decision_t d;
            logic      keep;
            keep = 1'b1;
            if (w.time_present || w.frame_present)
                keep = !timing_drop(w);
            if (!keep)
                d = '{1'b0, '0, 1'b0};
            else if (renumber)
            begin
                d = '{1'b1, out_count, 1'b1};
                out_count = out_count + 1'b1;
            end
            else
                d = '{1'b1, w.frame_present ? w.frame_index : '0, w.frame_present};
            pending_decisions.push_back(d);
        endfunction

        function void flag(string what, decision_t want, decision_t got);
            faults++;
            if (faults <= 10)
                $display("%s: expected pass %0b index %h present %0b, got pass %0b index %h present %0b",
                         what, want.pass_frame, want.frame_index_out, want.frame_present_out,
                         got.pass_frame, got.frame_index_out, got.frame_present_out);
        endfunction

        function void check_decision(decision_t got);
            decision_t want;
            if (pending_decisions.size() == 0)
            begin
                flag("unexpected decision", '0, got);
                return;
            end
            want = pending_decisions.pop_front();
            if (got !== want)
                flag("decision mismatch", want, got);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frbd_in_if  in_ch ();
    frbd_out_if out_ch ();

    frame_rate_burst_decimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    decision_scoreboard sb = new;

    // idling odds in percent, changed only between phases
    int unsigned idle_pct;
    int unsigned stall_pct;
    // time one bin at the current rate spans, and the furthest frame time sent so far;
    // sequences grow from the furthest time so that a stray early word does not stall them
    longint unsigned bin_step;
    longint unsigned lead_time;

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint unsigned clamp_time(longint unsigned t);
        return (t > TIME_MAX) ? TIME_MAX : t;
    endfunction

    function automatic frame_word_t make_frame(logic tp, logic fp, logic [TIME_W-1:0] t,
                                               logic [PERIOD_W-1:0] period,
                                               logic [INDEX_W-1:0] index);
        frame_word_t w;
        w = '{tp, fp, t, period, index};
        return w;
    endfunction

    // mostly well-formed timestamp streams with random content, some rewinds,
    // frames with no timing at all and a little plain noise
    function automatic frame_word_t random_frame();
        frame_word_t     w;
        longint unsigned step;
        int unsigned     kind;
        kind = $urandom_range(0, 99);
        step = bin_step * $urandom_range(0, 6) / 4 + $urandom_range(0, 15);
        w.time_present  = 1'($urandom);
        w.frame_present = 1'($urandom);
        w.frame_time    = TIME_W'({$urandom, $urandom});
        w.source_period = $urandom;
        w.frame_index   = $urandom;
        if (kind < 48)
        begin
            // timestamped frame up to a bin and a half on
            w.time_present = 1'b1;
            w.frame_time = TIME_W'(clamp_time(lead_time + step));
        end
        else if (kind < 70)
        begin
            // frame number only, time taken from the source period
            w.time_present = 1'b0;
            w.frame_present = 1'b1;
            w.source_period = PERIOD_W'((step > PERIOD_MAX) ? PERIOD_MAX : step);
        end
        else if (kind < 80)
        begin
            // neither time nor number: always forwarded
            w.time_present = 1'b0;
            w.frame_present = 1'b0;
        end
        else if (kind < 85)
        begin
            // timestamp running backwards
            w.time_present = 1'b1;
            w.frame_present = 1'b1;
            w.frame_time = TIME_W'((lead_time > step) ? lead_time - step : 64'd0);
        end
        else if (kind < 97)
            w.frame_time = TIME_W'(clamp_time(lead_time + $urandom));
        return w;
    endfunction

    // offers one word, idling beforehand at the phase's odds; valid is left high
    // after acceptance until the next offer or the end of the phase
    task automatic offer_frame(frame_word_t w);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.time_present  <= w.time_present;
        in_ch.frame_present <= w.frame_present;
        in_ch.frame_time    <= w.frame_time;
        in_ch.source_period <= w.source_period;
        in_ch.frame_index   <= w.frame_index;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_frame(w);
        if (64'(sb.cur_time) > lead_time)
            lead_time = 64'(sb.cur_time);
    endtask

    // waits until every decision is back and the block has gone quiet
    task automatic finish_phase();
        in_ch.valid <= 1'b0;
        while (sb.pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all four registers, one per cycle; junk above the burst and renumber
    // registers' widths checks that the block masks it off
    task automatic write_regs(logic [RATE_W-1:0] rate, logic [BURST_W-1:0] pass_n,
                              logic [BURST_W-1:0] skip_n, logic renum);
        cfg_reg_t              idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        idx = '{CFG_TARGET_RATE, CFG_BURST_PASS, CFG_BURST_SKIP, CFG_RENUMBER};
        val[0] = rate;
        val[1] = {16'($urandom), pass_n};
        val[2] = {16'($urandom), skip_n};
        val[3] = {31'($urandom), renum};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.note_config(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        bin_step = (rate == 0) ? (64'd1 << FRAC_BITS) : ((64'd1 << (FRAC_BITS + 16)) / rate);
    endtask

    task automatic run_phase(logic [RATE_W-1:0] rate, logic [BURST_W-1:0] pass_n,
                             logic [BURST_W-1:0] skip_n, logic renum, int count,
                             idle_mode_t mode);
        write_regs(rate, pass_n, skip_n, renum);
        case (mode)
            IDLE_SENDER:   begin idle_pct = 57; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 57; end
            IDLE_BOTH:     begin idle_pct = 17; stall_pct = 17; end
            default:       begin idle_pct = 0;  stall_pct = 0;  end
        endcase
        repeat (count) offer_frame(random_frame());
        finish_phase();
    endtask

    // receiver: checks each decision word taken, then picks next cycle's ready
    initial
    begin
        decision_t seen;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                seen = '{out_ch.pass_frame, out_ch.frame_index_out, out_ch.frame_present_out};
                sb.check_decision(seen);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        idle_pct  = 0;
        stall_pct = 0;
        lead_time = 0;
        bin_step  = 64'd1 << FRAC_BITS;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_TARGET_RATE;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.time_present  <= 1'b0;
        in_ch.frame_present <= 1'b0;
        in_ch.frame_time    <= '0;
        in_ch.source_period <= '0;
        in_ch.frame_index   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults, one frame per second, no burst gate, no renumbering
        // untimed frame passes and leaves the timing state alone
        offer_frame(make_frame(1'b0, 1'b0, '1, '0, '1));
        // first timed frame, time built from the period, always passes
        offer_frame(make_frame(1'b0, 1'b1, '0, 32'h0100_0000, '1));
        // same one-second bin as the previous pass: dropped
        offer_frame(make_frame(1'b1, 1'b1, 48'h0000_0180_0000, '0, 32'd5));
        // next bin, timestamp without a frame number
        offer_frame(make_frame(1'b1, 1'b0, 48'h0000_0200_0000, '0, 32'd7));
        // timestamp running backwards
        offer_frame(make_frame(1'b1, 1'b1, '0, '1, '0));
        finish_phase();

        // zero rate: all bins collapse to zero, so timed frames drop
        write_regs('0, 16'd3, 16'd2, 1'b1);
        offer_frame(make_frame(1'b1, 1'b1, '1, '0, 32'h1234_5678));
        // largest period on top of the largest time saturates the frame clock
        offer_frame(make_frame(1'b0, 1'b1, '0, '1, 32'h8000_0001));
        // untimed frame still passes and takes the next renumbered index
        offer_frame(make_frame(1'b0, 1'b0, '0, '0, '1));
        finish_phase();

        // slowest rate with a three-of-five burst gate; the rate change keeps the
        // old last-pass bin, so start past it and step half a bin at a time
        write_regs(32'd1, 16'd3, 16'd2, 1'b1);
        for (int k = 0; k <= 10; k++)
            offer_frame(make_frame(1'b1, 1'b1, (48'd3 << 40) + TIME_W'(k) * (48'd1 << 39),
                                   32'($urandom), 32'(k)));
        offer_frame(make_frame(1'b0, 1'b0, '0, '0, '0));
        finish_phase();
        lead_time = 64'(sb.cur_time);

        // random phases with rates mostly rising, so each new rate can still
        // move past the last passed bin left by the one before
        run_phase(32'd24 << 16, 16'd0, 16'd0, 1'b0, 100, IDLE_NONE);
        run_phase('0, 16'd0, 16'd7, 1'b1, 40, IDLE_SENDER);
        run_phase(32'h001D_F851, 16'd1, 16'hFFFF, 1'b0, 60, IDLE_BOTH);
        run_phase(32'd30 << 16, 16'd3, 16'd2, 1'b1, 100, IDLE_SENDER);
        run_phase(32'd60 << 16, 16'hFFFF, 16'd1, 1'b0, 100, IDLE_RECEIVER);
        run_phase(32'd240 << 16, 16'd5, 16'd0, 1'b1, 80, IDLE_BOTH);
        run_phase(32'($urandom_range(32'd240 << 16, 32'h7FFF_FFFF)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)), 1'b1, 100, IDLE_NONE);
        run_phase('1, 16'hFFFF, 16'hFFFF, 1'b0, 100, IDLE_RECEIVER);

        if (sb.faults == 0 && sb.pending_decisions.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
sv/frbd_pkg.sv
sv/frbd_in_if.sv
sv/frbd_out_if.sv
sv/frbd_alu.sv
sv/frbd_seq.sv
sv/frame_rate_burst_decimator.sv
sv/frbd_checker.sv
bench/frame_rate_burst_decimator_test.sv
